FILE: rtl/trsp_pkg.sv
// Package for the typed record stream parser.
// Holds the parse phase codes, event codes, type bytes and the input stage record.
// No dependencies.
`timescale 1ns / 1ps

package trsp_pkg;

	// Parse phase codes.
	localparam logic [3:0] PH_HDR_LO   = 4'd0;
	localparam logic [3:0] PH_HDR_HI   = 4'd1;
	localparam logic [3:0] PH_REC      = 4'd2;
	localparam logic [3:0] PH_CNT_LO   = 4'd3;
	localparam logic [3:0] PH_CNT_HI   = 4'd4;
	localparam logic [3:0] PH_TYPE     = 4'd5;
	localparam logic [3:0] PH_I_LO     = 4'd6;
	localparam logic [3:0] PH_I_HI     = 4'd7;
	localparam logic [3:0] PH_S_LO     = 4'd8;
	localparam logic [3:0] PH_S_HI     = 4'd9;
	localparam logic [3:0] PH_B_VAL    = 4'd10;
	localparam logic [3:0] PH_BYTE_VAL = 4'd11;
	localparam logic [3:0] PH_DONE     = 4'd12;

	// Event codes on the output channel.
	localparam logic [3:0] EV_HDR_UNIT   = 4'd0;
	localparam logic [3:0] EV_HDR_END    = 4'd1;
	localparam logic [3:0] EV_REC_START  = 4'd2;
	localparam logic [3:0] EV_EMPTY      = 4'd3;
	localparam logic [3:0] EV_UINT16     = 4'd4;
	localparam logic [3:0] EV_STR_UNIT   = 4'd5;
	localparam logic [3:0] EV_STR_END    = 4'd6;
	localparam logic [3:0] EV_BOOL       = 4'd7;
	localparam logic [3:0] EV_BYTE       = 4'd8;
	localparam logic [3:0] EV_BAD_TYPE   = 4'd9;
	localparam logic [3:0] EV_STREAM_END = 4'd10;

	// Entry type bytes.
	localparam logic [7:0] TYPE_EMPTY  = 8'h45; // 'E'
	localparam logic [7:0] TYPE_UINT16 = 8'h49; // 'I'
	localparam logic [7:0] TYPE_STRING = 8'h53; // 'S'
	localparam logic [7:0] TYPE_BOOL   = 8'h42; // 'B'
	localparam logic [7:0] TYPE_BYTE   = 8'h62; // 'b'

	// High surrogate range of UTF-16.
	localparam logic [15:0] SUR_LO = 16'hD800;
	localparam logic [15:0] SUR_HI = 16'hDBFF;

	// Record marker after reset.
	localparam logic [7:0] MARKER_RESET = 8'd77;

	// Contents of the input stage.
	typedef struct packed {
		logic [7:0] data_byte;
		logic       first;
	} in_stage_t;

endpackage

FILE: rtl/trsp_ifs.sv
// Handshake interfaces of the typed record stream parser.
// Byte request channel and event channel; no dependencies.
`timescale 1ns / 1ps

interface trsp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       first;

	modport source (output valid, output data_byte, output first, input ready);
	modport sink (input valid, input data_byte, input first, output ready);
endinterface

interface trsp_event_if;
	logic        valid;
	logic        ready;
	logic [3:0]  event_res;
	logic [15:0] value;
	logic [15:0] entries_left;
	logic        surrogate_flag;

	modport source (output valid, output event_res, output value, output entries_left,
		output surrogate_flag, input ready);
	modport sink (input valid, input event_res, input value, input entries_left,
		input surrogate_flag, output ready);
endinterface

FILE: rtl/trsp_in_reg.sv
// Input register stage of the typed record stream parser.
// Depends on trsp_pkg and trsp_byte_if.
`timescale 1ns / 1ps

module trsp_in_reg
	import trsp_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	trsp_byte_if.sink       req_in,
	input  logic            advance,
	output logic            valid_s1,
	output in_stage_t       stage_s1
);

	// The stage takes a new request when empty or when its item moves on.
	assign req_in.ready = !valid_s1 || advance;

	// Valid flag of the stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_in.valid && req_in.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// Payload of the stage.
	always_ff @(posedge clk) begin
		if (req_in.valid && req_in.ready) begin
			stage_s1.data_byte <= req_in.data_byte;
			stage_s1.first     <= req_in.first;
		end
	end

endmodule

FILE: rtl/trsp_core.sv
// Parse state, one-byte step logic and event register of the parser.
// Depends on trsp_pkg and trsp_event_if.
`timescale 1ns / 1ps

module trsp_core
	import trsp_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_we,
	input  logic [7:0]      cfg_wdata,
	input  logic            valid_s1,
	input  in_stage_t       stage_s1,
	trsp_event_if.source    evt_out,
	output logic            advance
);

	logic [7:0]  marker_q;
	logic [3:0]  phase_q;
	logic [7:0]  held_q;
	logic [15:0] entries_q;

	logic [3:0]  cur_phase;
	logic [7:0]  cur_held;
	logic [15:0] cur_entries;
	logic [15:0] unit;
	logic        unit_sur;
	logic [15:0] ent_dec;
	logic [3:0]  done_phase;

	logic [3:0]  nxt_phase;
	logic [7:0]  nxt_held;
	logic [15:0] nxt_entries;
	logic        emit;
	logic [3:0]  ev_code;
	logic [15:0] ev_value;
	logic        ev_sur;

	logic        valid_s2;
	logic [3:0]  event_s2;
	logic [15:0] value_s2;
	logic [15:0] entries_s2;
	logic        sur_s2;

	// Record marker register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			marker_q <= MARKER_RESET;
		end else if (cfg_we) begin
			marker_q <= cfg_wdata;
		end
	end

	// A restart clears the state before the byte is taken.
	assign cur_phase   = stage_s1.first ? PH_HDR_LO : phase_q;
	assign cur_held    = stage_s1.first ? 8'd0 : held_q;
	assign cur_entries = stage_s1.first ? 16'd0 : entries_q;
	assign unit        = {stage_s1.data_byte, cur_held};
	assign unit_sur    = (unit >= SUR_LO) && (unit <= SUR_HI);
	assign ent_dec     = cur_entries - 16'd1;

	// Step logic for one byte.
	always_comb begin
		nxt_phase   = cur_phase;
		nxt_held    = cur_held;
		nxt_entries = cur_entries;
		emit        = 1'b0;
		ev_code     = EV_HDR_UNIT;
		ev_value    = 16'd0;
		ev_sur      = 1'b0;
		done_phase  = (cur_entries == 16'd0) ? PH_REC : PH_TYPE;
		case (cur_phase)
			PH_HDR_LO, PH_CNT_LO, PH_I_LO, PH_S_LO: begin
				nxt_held  = stage_s1.data_byte;
				nxt_phase = cur_phase + 4'd1;
			end
			PH_HDR_HI: begin
				emit = 1'b1;
				if (unit == 16'd0) begin
					nxt_phase = PH_REC;
					ev_code   = EV_HDR_END;
				end else begin
					nxt_phase = PH_HDR_LO;
					ev_code   = EV_HDR_UNIT;
					ev_value  = unit;
					ev_sur    = unit_sur;
				end
			end
			PH_REC: begin
				if (stage_s1.data_byte == marker_q) begin
					nxt_phase = PH_CNT_LO;
				end else begin
					nxt_phase = PH_DONE;
					emit      = 1'b1;
					ev_code   = EV_STREAM_END;
				end
			end
			PH_CNT_HI: begin
				nxt_entries = unit;
				nxt_phase   = (unit == 16'd0) ? PH_REC : PH_TYPE;
				emit        = 1'b1;
				ev_code     = EV_REC_START;
				ev_value    = unit;
			end
			PH_TYPE: begin
				nxt_entries = ent_dec;
				done_phase  = (ent_dec == 16'd0) ? PH_REC : PH_TYPE;
				case (stage_s1.data_byte)
					TYPE_EMPTY: begin
						nxt_phase = done_phase;
						emit      = 1'b1;
						ev_code   = EV_EMPTY;
					end
					TYPE_UINT16: nxt_phase = PH_I_LO;
					TYPE_STRING: nxt_phase = PH_S_LO;
					TYPE_BOOL:   nxt_phase = PH_B_VAL;
					TYPE_BYTE:   nxt_phase = PH_BYTE_VAL;
					default: begin
						nxt_phase = done_phase;
						emit      = 1'b1;
						ev_code   = EV_BAD_TYPE;
						ev_value  = {8'd0, stage_s1.data_byte};
					end
				endcase
			end
			PH_I_HI: begin
				nxt_phase = done_phase;
				emit      = 1'b1;
				ev_code   = EV_UINT16;
				ev_value  = unit;
			end
			PH_S_HI: begin
				emit = 1'b1;
				if (unit == 16'd0) begin
					nxt_phase = done_phase;
					ev_code   = EV_STR_END;
				end else begin
					nxt_phase = PH_S_LO;
					ev_code   = EV_STR_UNIT;
					ev_value  = unit;
					ev_sur    = unit_sur;
				end
			end
			PH_B_VAL: begin
				nxt_phase = done_phase;
				emit      = 1'b1;
				ev_code   = EV_BOOL;
				ev_value  = {15'd0, (stage_s1.data_byte != 8'd0)};
			end
			PH_BYTE_VAL: begin
				nxt_phase = done_phase;
				emit      = 1'b1;
				ev_code   = EV_BYTE;
				ev_value  = {8'd0, stage_s1.data_byte};
			end
			default: begin
				// Stream has ended, or an unused code: bytes are dropped.
				nxt_phase = PH_DONE;
			end
		endcase
	end

	// The byte moves on unless its event would overwrite a waiting one.
	assign advance = valid_s1 && (!emit || !valid_s2 || evt_out.ready);

	// Parse state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_HDR_LO;
			held_q    <= 8'd0;
			entries_q <= 16'd0;
		end else if (advance) begin
			phase_q   <= nxt_phase;
			held_q    <= nxt_held;
			entries_q <= nxt_entries;
		end
	end

	// Event register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance && emit) begin
			valid_s2 <= 1'b1;
		end else if (evt_out.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	// Event register payload.
	always_ff @(posedge clk) begin
		if (advance && emit) begin
			event_s2   <= ev_code;
			value_s2   <= ev_value;
			entries_s2 <= nxt_entries;
			sur_s2     <= ev_sur;
		end
	end

	assign evt_out.valid          = valid_s2;
	assign evt_out.event_res      = event_s2;
	assign evt_out.value          = value_s2;
	assign evt_out.entries_left   = entries_s2;
	assign evt_out.surrogate_flag = sur_s2;

endmodule

FILE: rtl/typed_record_stream_parser.sv
// Top level of the typed record stream parser.
// Depends on trsp_pkg, trsp_ifs, trsp_in_reg and trsp_core.
`timescale 1ns / 1ps

// The parser takes one byte request per clock cycle and gives at most one event per
// byte. A byte goes into an input register, and a single step of the parse state
// machine between that register and the event register turns it into an event; the
// two registers let a new byte be taken while an earlier event still waits on the
// output. A stall on the event channel holds back input only when the byte in the
// input register would itself produce an event. The record marker is written through
// cfg_we and cfg_wdata; the user must write it only while the parser is idle, as the
// block itself does not enforce it. A byte with first set restarts parsing at the header.

module typed_record_stream_parser
	import trsp_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	trsp_byte_if.sink       req_in,
	trsp_event_if.source    evt_out,
	input  logic            cfg_we,
	input  logic [7:0]      cfg_wdata
);

	logic      advance;
	logic      valid_s1;
	in_stage_t stage_s1;

	// Input register stage.
	trsp_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_in   (req_in),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.stage_s1 (stage_s1)
	);

	// Parse step and event register.
	trsp_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.valid_s1  (valid_s1),
		.stage_s1  (stage_s1),
		.evt_out   (evt_out),
		.advance   (advance)
	);

	// Input is refused only while a byte is waiting in the input register.
	assert property (@(posedge clk) disable iff (!arst_n)
		!req_in.ready |-> valid_s1)
		else $error("input stalled with an empty input register");

	// The surrogate flag belongs to header and string units only.
	assert property (@(posedge clk) disable iff (!arst_n)
		(evt_out.valid && evt_out.surrogate_flag) |->
		(evt_out.event_res == EV_HDR_UNIT || evt_out.event_res == EV_STR_UNIT))
		else $error("surrogate flag on a non-unit event");

	// Header events come before any record, so no entries are outstanding.
	assert property (@(posedge clk) disable iff (!arst_n)
		(evt_out.valid &&
		(evt_out.event_res == EV_HDR_UNIT || evt_out.event_res == EV_HDR_END)) |->
		(evt_out.entries_left == 16'd0))
		else $error("entries outstanding during the header");

	// A byte leaving the input register frees it unless a new one arrives.
	assert property (@(posedge clk) disable iff (!arst_n)
		(advance && !req_in.valid) |=> !valid_s1)
		else $error("input register not emptied after its byte moved on");

endmodule
